>>> rtl/core/slcp_pkg.sv
// slcp_pkg: shared constants, types and character tables for the serial line
// command parser. No dependencies; every other file imports it.
`default_nettype none

package slcp_pkg;

  // bytes kept per line, and the width of the line counter
  localparam int LINE_KEEP = 31;
  localparam int CNT_W     = $clog2(LINE_KEEP + 1);

  // gain after reset, in hundredths
  localparam logic signed [31:0] GAIN_RESET = 32'sd100;

  // special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // match flag bits
  localparam int FLAG_GET_T  = 0;
  localparam int FLAG_GET_P  = 1;
  localparam int FLAG_GET_K  = 2;
  localparam int FLAG_GET_A  = 3;
  localparam int FLAG_PREFIX = 4;
  localparam logic [5:0] FLAGS_ALL = 6'h3F;

  // lengths of the exact words and of the set prefix
  localparam int EXACT_LEN  = 5;
  localparam int PREFIX_LEN = 6;

  // result command codes
  typedef enum logic [2:0] {
    CMD_UNKNOWN   = 3'd0,
    CMD_GET_T     = 3'd1,
    CMD_GET_P     = 3'd2,
    CMD_SET_K_OK  = 3'd3,
    CMD_SET_K_ERR = 3'd4,
    CMD_GET_K     = 3'd5,
    CMD_GET_A     = 3'd6
  } cmd_t;

  // number reader phases
  typedef enum logic [1:0] {
    NUM_SKIP = 2'd0,
    NUM_IN   = 2'd1,
    NUM_DONE = 2'd2
  } num_phase_t;

  // line tracker to number reader
  typedef struct packed {
    logic feed;
    logic clear;
  } num_ctrl_t;

  // number reader status
  typedef struct packed {
    logic               digit_seen;
    logic signed [31:0] value;
  } num_stat_t;

  // line tracker result for the current word
  typedef struct packed {
    logic valid;
    logic set_gain;
    cmd_t cmd;
  } line_res_t;

  // character k of an exact word at position p (p below EXACT_LEN)
  function automatic logic [7:0] exact_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0: c = 8'h47;    // G
      3'd1: c = 8'h45;    // E
      3'd2: c = 8'h54;    // T
      3'd3: c = 8'h5F;    // _
      3'd4: begin
        case (k)
          2'd0: c = 8'h54;  // T
          2'd1: c = 8'h50;  // P
          2'd2: c = 8'h4B;  // K
          default: c = 8'h41;  // A
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // character of the set prefix at position p (p below PREFIX_LEN)
  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0: c = 8'h53;    // S
      3'd1: c = 8'h45;    // E
      3'd2: c = 8'h54;    // T
      3'd3: c = 8'h5F;    // _
      3'd4: c = 8'h4B;    // K
      3'd5: c = 8'h3D;    // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/slcp_if.sv
// slcp_if: valid/ready channel interfaces for received bytes and results.
// Depends on slcp_pkg by import; the payloads are plain bit vectors.
`default_nettype none

interface slcp_in_if import slcp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcp_out_if import slcp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] gain_hundredths;

  modport source (output valid, output command, output gain_hundredths, input ready);
  modport sink   (input valid, input command, input gain_hundredths, output ready);
endinterface

`default_nettype wire

>>> rtl/core/slcp_num.sv
// slcp_num: decimal reader for the text after the set prefix, one byte per step.
// Depends on slcp_pkg (phases, characters, control and status structs).
`default_nettype none

module slcp_num import slcp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data,
  input  wire num_ctrl_t  ctrl,
  output num_stat_t       stat
);

  num_phase_t  phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        seen_r, seen_nxt;
  logic [31:0] accum_r, accum_nxt;

  logic        is_digit, is_blank, is_sign;
  logic        take_digit, take_sign;
  logic [35:0] prod;
  logic [31:0] accum_dig;

  // byte classes
  assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);
  assign is_blank = (data == CH_SPACE) || (data == CH_HT) || (data == CH_VT) ||
                    (data == CH_FF);
  assign is_sign  = (data == CH_PLUS) || (data == CH_MINUS);

  // accum * 10 + digit, held at 2^31
  assign prod = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0} + {32'd0, data[3:0]};
  assign accum_dig = (prod > 36'h0_8000_0000) ? 32'h8000_0000 : prod[31:0];

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      NUM_SKIP: begin
        if (is_blank) phase_nxt = NUM_SKIP;
        else if (is_sign || is_digit) phase_nxt = NUM_IN;
        else phase_nxt = NUM_DONE;
      end
      NUM_IN: begin
        if (!is_digit) phase_nxt = NUM_DONE;
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // phase outputs
  always_comb begin
    take_digit = 1'b0;
    take_sign  = 1'b0;
    case (phase_r)
      NUM_SKIP: begin
        take_sign  = is_sign && !is_blank;
        take_digit = is_digit;
      end
      NUM_IN: take_digit = is_digit;
      default: begin
        take_digit = 1'b0;
        take_sign  = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    accum_nxt = accum_r;
    if (take_sign) neg_nxt = (data == CH_MINUS);
    if (take_digit) begin
      accum_nxt = accum_dig;
      seen_nxt  = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= NUM_SKIP;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      accum_r <= '0;
    end else if (step) begin
      if (ctrl.clear) begin
        phase_r <= NUM_SKIP;
        neg_r   <= 1'b0;
        seen_r  <= 1'b0;
        accum_r <= '0;
      end else if (ctrl.feed) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        seen_r  <= seen_nxt;
        accum_r <= accum_nxt;
      end
    end
  end

  // saturated signed value
  always_comb begin
    stat.digit_seen = seen_r;
    if (neg_r) stat.value = $signed(32'd0 - accum_r);
    else if (accum_r[31]) stat.value = 32'sh7FFF_FFFF;
    else stat.value = $signed(accum_r);
  end

endmodule

`default_nettype wire

>>> rtl/core/slcp_line.sv
// slcp_line: line tracker with incremental word matching and command decode.
// Depends on slcp_pkg (character tables, flags, command codes, structs).
`default_nettype none

module slcp_line import slcp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data,
  input  wire num_stat_t  num,
  output num_ctrl_t       num_ctrl,
  output line_res_t       res
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ended_r, ended_nxt;
  logic [5:0]       flags_r, flags_nxt;

  logic             is_term, keep;
  logic [5:0]       flags_eff;
  logic [2:0]       pos;

  assign is_term = (data == CH_LF) || (data == CH_CR);
  assign keep    = (count_r < CNT_W'(LINE_KEEP));
  assign pos     = count_r[2:0];

  // byte update of count, end mark and match flags
  always_comb begin
    count_nxt     = count_r;
    ended_nxt     = ended_r;
    flags_nxt     = flags_r;
    num_ctrl.feed = 1'b0;
    num_ctrl.clear = is_term;
    if (is_term) begin
      count_nxt = '0;
      ended_nxt = 1'b0;
      flags_nxt = FLAGS_ALL;
    end else if (keep) begin
      count_nxt = count_r + CNT_W'(1);
      if (!ended_r) begin
        if (data == CH_NUL) begin
          ended_nxt = 1'b1;
          if (count_r < CNT_W'(EXACT_LEN)) flags_nxt[FLAG_GET_A:FLAG_GET_T] = 4'b0000;
          if (count_r < CNT_W'(PREFIX_LEN)) flags_nxt[FLAG_PREFIX] = 1'b0;
        end else begin
          for (int k = 0; k < 4; k++) begin
            if (count_r >= CNT_W'(EXACT_LEN) || data != exact_char(2'(k), pos))
              flags_nxt[k] = 1'b0;
          end
          if (count_r < CNT_W'(PREFIX_LEN)) begin
            if (data != prefix_char(pos)) flags_nxt[FLAG_PREFIX] = 1'b0;
          end else begin
            num_ctrl.feed = flags_r[FLAG_PREFIX];
          end
        end
      end
    end
  end

  // flags as judged at the end of the line
  always_comb begin
    flags_eff = flags_r;
    if (!ended_r) begin
      if (count_r < CNT_W'(EXACT_LEN)) flags_eff[FLAG_GET_A:FLAG_GET_T] = 4'b0000;
      if (count_r < CNT_W'(PREFIX_LEN)) flags_eff[FLAG_PREFIX] = 1'b0;
    end
  end

  // command decode in priority order
  always_comb begin
    res.valid    = is_term && (count_r != '0);
    res.set_gain = 1'b0;
    res.cmd      = CMD_UNKNOWN;
    if (flags_eff[FLAG_GET_T]) begin
      res.cmd = CMD_GET_T;
    end else if (flags_eff[FLAG_GET_P]) begin
      res.cmd = CMD_GET_P;
    end else if (flags_eff[FLAG_PREFIX]) begin
      if (num.digit_seen) begin
        res.cmd      = CMD_SET_K_OK;
        res.set_gain = res.valid;
      end else begin
        res.cmd = CMD_SET_K_ERR;
      end
    end else if (flags_eff[FLAG_GET_K]) begin
      res.cmd = CMD_GET_K;
    end else if (flags_eff[FLAG_GET_A]) begin
      res.cmd = CMD_GET_A;
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ended_r <= 1'b0;
      flags_r <= FLAGS_ALL;
    end else if (step) begin
      count_r <= count_nxt;
      ended_r <= ended_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/serial_line_command_parser_unit.sv
// serial_line_command_parser_unit: byte input register, line tracker, number
// reader, gain store and result register. Depends on slcp_pkg, slcp_if, slcp_line, slcp_num.
// A result word is registered when its terminator is stepped out of the input register.
// Throughput: one byte per cycle; the input register and the result register decouple
// the two channels, and only a waiting result blocks the step of the next byte.
// Reset (rst_n low at a clock edge): line state cleared, gain set to 100 hundredths,
// no word held in either register.
`default_nettype none

module serial_line_command_parser_unit import slcp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  slcp_in_if.sink     in_chan,
  slcp_out_if.source  out_chan
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               out_valid_r;
  logic [2:0]         out_cmd_r;
  logic signed [31:0] out_gain_r;
  logic signed [31:0] gain_r;

  logic               advance, step, in_take;
  num_ctrl_t          num_ctrl;
  num_stat_t          num_stat;
  line_res_t          res;

  // handshake control
  assign advance       = !out_valid_r || out_chan.ready;
  assign step          = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_byte_r <= in_chan.rx_byte;
  end

  // line tracking and number reading
  slcp_line u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .data     (s1_byte_r),
    .num      (num_stat),
    .num_ctrl (num_ctrl),
    .res      (res)
  );

  slcp_num u_num (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .data  (s1_byte_r),
    .ctrl  (num_ctrl),
    .stat  (num_stat)
  );

  // gain store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (step && res.set_gain) begin
      gain_r <= num_stat.value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_cmd_r  <= res.cmd;
      out_gain_r <= res.set_gain ? num_stat.value : gain_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.command         = out_cmd_r;
  assign out_chan.gain_hundredths = out_gain_r;

endmodule

`default_nettype wire
